>>> src/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg: shared definitions for the sliding window min/max/mean block
// Payload structs, default sizes and sequencer states.
// ----------------------------------------------------------------------------
package swmm_pkg;

    localparam int SAMPLE_W            = 24;
    localparam int SLOT_W              = 7;
    localparam int WINDOW_LENGTH_DEF   = 100;
    localparam int SAMPLE_BITS_DEF     = 24;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
    } swmm_in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] window_min;
        logic [SAMPLE_W-1:0] window_max;
        logic [SAMPLE_W-1:0] window_mean;
        logic [SLOT_W-1:0]   next_slot;
    } swmm_out_t;

    typedef enum logic [2:0] {
        SWMM_IDLE,
        SWMM_SCAN,
        SWMM_DRAIN,
        SWMM_LOAD,
        SWMM_DIV,
        SWMM_DONE
    } swmm_state_t;

endpackage

>>> src/swmm_stream_if.sv
// ----------------------------------------------------------------------------
// swmm_stream_if: valid/ready channel
// A transfer takes place at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface swmm_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/swmm_ram.sv
// ----------------------------------------------------------------------------
// swmm_ram: simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module swmm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 100
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/sliding_window_min_max_mean.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max_mean: min, max and mean over the last samples
// Ring store in RAM, sequential scan and reciprocal-multiply divide per sample.
// ----------------------------------------------------------------------------
// Each transfer on samples overwrites the oldest of WINDOW_LENGTH ring
// entries and yields one transfer on stats with the minimum, maximum and
// truncated mean over all entries, and the slot written next. Entries not
// yet written count as zero. The sample is written at its transfer edge;
// then the ring is read entry by entry through the single RAM read port,
// the read pipeline is drained, the sum is multiplied by the reciprocal of
// WINDOW_LENGTH as a split multiply, and the result is registered. samples
// is ready again once the result sits in the output register, so a new
// sample is not taken while the previous one is still being processed; it is
// taken even if stats has not yet taken the previous result. A result that
// stats holds off delays the next one in its last step. Reset needs no
// clearing pass: a fill count marks the written entries.
// ----------------------------------------------------------------------------
module sliding_window_min_max_mean #(
    parameter int WINDOW_LENGTH = swmm_pkg::WINDOW_LENGTH_DEF,
    parameter int SAMPLE_BITS   = swmm_pkg::SAMPLE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    swmm_stream_if.sink   samples,
    swmm_stream_if.source stats
);

    localparam int AW    = $clog2(WINDOW_LENGTH);
    localparam int FW    = $clog2(WINDOW_LENGTH + 1);
    localparam int SUM_W = SAMPLE_BITS + AW;
    localparam int RS    = SUM_W + AW;
    localparam int MW    = SUM_W + 1;
    localparam int MH    = (MW + 1) / 2;
    localparam int PW    = SUM_W + MW;
    localparam int OW    = swmm_pkg::SAMPLE_W;
    localparam int SW    = swmm_pkg::SLOT_W;

    localparam longint unsigned RECIP =
        ((64'd1 << RS) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
    localparam logic [MH-1:0]    RECIP_LO = RECIP[MH-1:0];
    localparam logic [MW-MH-1:0] RECIP_HI = RECIP[MW-1:MH];

    swmm_pkg::swmm_state_t state_reg, state_next;

    logic [AW-1:0]          pos_reg, pos_next;
    logic [FW-1:0]          fill_reg, fill_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic                   dvld_reg, dvld_next;
    logic                   dfirst_reg, dfirst_next;
    logic                   dzero_reg, dzero_next;
    logic [SAMPLE_BITS-1:0] min_reg, min_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [PW-1:0]          prod_reg, prod_next;
    logic                   ovld_reg, ovld_next;
    swmm_pkg::swmm_out_t    out_reg, out_next;

    logic                   in_fire;
    logic                   ram_we;
    logic                   ram_re;
    logic [SAMPLE_BITS-1:0] sample_val;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic [SAMPLE_BITS-1:0] entry;

    assign samples.ready = (state_reg == swmm_pkg::SWMM_IDLE);
    assign in_fire       = samples.valid && samples.ready;
    assign stats.valid   = ovld_reg;
    assign stats.data    = out_reg;

    assign sample_val = SAMPLE_BITS'({{32{1'b0}}, samples.data.sample});
    assign ram_we     = in_fire;
    assign ram_re     = (state_reg == swmm_pkg::SWMM_SCAN);

    swmm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_LENGTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (sample_val),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    assign entry = dzero_reg ? '0 : rd_data;

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        dvld_next   = 1'b0;
        dfirst_next = dfirst_reg;
        dzero_next  = dzero_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        sum_next    = sum_reg;
        prod_next   = prod_reg;
        ovld_next   = ovld_reg;
        out_next    = out_reg;

        if (ovld_reg && stats.ready)
        begin
            ovld_next = 1'b0;
        end

        // accumulate the entry returned by the previous read
        if (dvld_reg)
        begin
            if (dfirst_reg)
            begin
                min_next = entry;
                max_next = entry;
                sum_next = SUM_W'(entry);
            end
            else
            begin
                if (entry < min_reg)
                begin
                    min_next = entry;
                end
                if (entry > max_reg)
                begin
                    max_next = entry;
                end
                sum_next = sum_reg + SUM_W'(entry);
            end
        end

        case (state_reg)
            swmm_pkg::SWMM_IDLE:
            begin
                if (in_fire)
                begin
                    pos_next = (pos_reg == AW'(WINDOW_LENGTH - 1)) ? '0 : pos_reg + 1'b1;
                    if (fill_reg != FW'(WINDOW_LENGTH))
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    idx_next   = '0;
                    state_next = swmm_pkg::SWMM_SCAN;
                end
            end
            swmm_pkg::SWMM_SCAN:
            begin
                dvld_next   = 1'b1;
                dfirst_next = (idx_reg == '0);
                dzero_next  = (FW'(idx_reg) >= fill_reg);
                if (idx_reg == AW'(WINDOW_LENGTH - 1))
                begin
                    state_next = swmm_pkg::SWMM_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            swmm_pkg::SWMM_DRAIN:
            begin
                state_next = swmm_pkg::SWMM_LOAD;
            end
            swmm_pkg::SWMM_LOAD:
            begin
                prod_next  = PW'(sum_reg) * PW'(RECIP_LO);
                state_next = swmm_pkg::SWMM_DIV;
            end
            swmm_pkg::SWMM_DIV:
            begin
                prod_next  = prod_reg + ((PW'(sum_reg) * PW'(RECIP_HI)) << MH);
                state_next = swmm_pkg::SWMM_DONE;
            end
            swmm_pkg::SWMM_DONE:
            begin
                if (!ovld_reg || stats.ready)
                begin
                    ovld_next            = 1'b1;
                    out_next.window_min  = OW'({{OW{1'b0}}, min_reg});
                    out_next.window_max  = OW'({{OW{1'b0}}, max_reg});
                    out_next.window_mean = OW'({{OW{1'b0}}, prod_reg[RS +: SAMPLE_BITS]});
                    out_next.next_slot   = SW'({{SW{1'b0}}, pos_reg});
                    state_next           = swmm_pkg::SWMM_IDLE;
                end
            end
            default:
            begin
                state_next = swmm_pkg::SWMM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swmm_pkg::SWMM_IDLE;
            pos_reg   <= '0;
            fill_reg  <= '0;
            idx_reg   <= '0;
            dvld_reg  <= 1'b0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            dvld_reg  <= dvld_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dfirst_reg <= dfirst_next;
        dzero_reg  <= dzero_next;
        min_reg    <= min_next;
        max_reg    <= max_next;
        sum_reg    <= sum_next;
        prod_reg   <= prod_next;
        out_reg    <= out_next;
    end

endmodule

>>> src/swmm_checker.sv
// ----------------------------------------------------------------------------
// swmm_checker: port-level checks for sliding_window_min_max_mean
// Watches both channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module swmm_checker #(
    parameter int WINDOW_LENGTH = swmm_pkg::WINDOW_LENGTH_DEF
) (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input swmm_pkg::swmm_out_t out_data
);

    logic in_fire;

    assign in_fire = in_valid && in_ready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("stalled result changed");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(out_data.next_slot) < WINDOW_LENGTH))
        else $error("next_slot out of range");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.window_min <= out_data.window_mean)
                   && (out_data.window_mean <= out_data.window_max))
        else $error("mean outside min/max");

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !$rose(out_valid))
        else $error("result appeared before scan completed");

endmodule

bind sliding_window_min_max_mean swmm_checker #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
) u_swmm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (stats.valid),
    .out_ready (stats.ready),
    .out_data  (stats.data)
);
